@@ hw/rtl/srst_pkg.sv @@
// Shared types and constants of the sorted range set tracker.
package srst_pkg;

    localparam int CFG_DATA_W  = 48;
    localparam int SEG_W       = 32;
    localparam int CHUNK_W     = 32;
    localparam int PROD_W      = 64;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_MARK    = 2'd0,
        OP_QUERY   = 2'd1,
        OP_SEGMENT = 2'd2,
        OP_CLIP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REVERSED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        CFG_TOTAL_SIZE = 1'b0,
        CFG_CHUNK_SIZE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_KEYS,
        S_SCAN,
        S_DECIDE,
        S_REWRITE,
        S_FLUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic keys;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic rw_start;
        logic rw_step;
        logic flush;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic pass_done;
        logic need_rewrite;
    } stat_t;

endpackage

@@ hw/rtl/srst_ctrl.sv @@
// Sequencer of the sorted range set tracker: item intake, table passes, result handoff.
module srst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  srst_pkg::stat_t     stat,
    output srst_pkg::cmd_t      cmd
);

    srst_pkg::state_t state_reg;
    srst_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srst_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            srst_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = srst_pkg::S_PREP;
                end
            end
            srst_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = srst_pkg::S_KEYS;
            end
            srst_pkg::S_KEYS:
            begin
                cmd.keys       = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = srst_pkg::S_SCAN;
            end
            srst_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.pass_done)
                begin
                    state_next = srst_pkg::S_DECIDE;
                end
            end
            srst_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.need_rewrite)
                begin
                    cmd.rw_start = 1'b1;
                    state_next   = srst_pkg::S_REWRITE;
                end
                else
                begin
                    state_next = srst_pkg::S_DONE;
                end
            end
            srst_pkg::S_REWRITE:
            begin
                cmd.rw_step = 1'b1;
                if (stat.pass_done)
                begin
                    state_next = srst_pkg::S_FLUSH;
                end
            end
            srst_pkg::S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = srst_pkg::S_DONE;
            end
            srst_pkg::S_DONE:
            begin
                // The result waits here only while the previous one is still held.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = srst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ hw/rtl/srst_datapath.sv @@
// Datapath of the sorted range set tracker: range table memory, walk logic, result register.
module srst_datapath
#(
    parameter int MAX_RANGES                  = 64,
    parameter int OFFSET_BITS                 = 48,
    parameter int unsigned DEFAULT_CHUNK_SIZE = 1048576
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srst_pkg::cmd_t                       cmd,
    output srst_pkg::stat_t                      stat,
    input  logic [1:0]                           in_op,
    input  logic [OFFSET_BITS-1:0]               in_first,
    input  logic [OFFSET_BITS-1:0]               in_last,
    input  logic [srst_pkg::SEG_W-1:0]           in_seg,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [srst_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [1:0]                           res_status,
    output logic                                 res_covered,
    output logic [OFFSET_BITS:0]                 res_bytes,
    output logic                                 res_all,
    output logic [srst_pkg::COUNT_OUT_W-1:0]     res_count
);

    localparam int OB = OFFSET_BITS;
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = 2 * OB;
    localparam int PW = srst_pkg::PROD_W;

    // Configuration and table state.
    logic [OB-1:0]                    total_reg;
    logic [srst_pkg::CHUNK_W-1:0]     chunk_reg;
    logic [CW-1:0]                    count_reg;
    logic [EW-1:0]                    mem [MAX_RANGES];
    logic [EW-1:0]                    rdata_reg;

    // Item registers.
    srst_pkg::op_t                    op_reg;
    logic [OB-1:0]                    first_in_reg;
    logic [OB-1:0]                    last_in_reg;
    logic [srst_pkg::SEG_W-1:0]       seg_reg;
    logic [PW-1:0]                    prod_reg;
    logic [OB-1:0]                    key_lo_reg;
    logic [OB-1:0]                    key_hi_reg;
    logic                             reversed_reg;
    logic                             past_reg;
    logic                             nocov_reg;

    // Walk state.
    logic [CW-1:0]                    rd_idx_reg;
    logic                             pv_reg;
    logic                             head_reg;
    logic                             cov_reg;
    logic                             touch_reg;
    logic [OB:0]                      sum_reg;
    logic                             all_reg;
    logic [CW-1:0]                    w_reg;
    logic                             carry_v_reg;
    logic [EW-1:0]                    carry_reg;
    logic                             emitted_reg;
    logic [OB-1:0]                    mlo_reg;
    logic [OB-1:0]                    mhi_reg;
    srst_pkg::status_t                status_reg;
    logic                             cov_out_reg;

    logic [srst_pkg::CHUNK_W-1:0]     csize;
    logic [PW-1:0]                    prod_c;
    logic [PW-1:0]                    hi64;
    logic [PW-1:0]                    total64;
    logic [OB-1:0]                    tm1;
    logic                             size_known;
    logic [63:0]                      cfg_ext;
    logic [OB-1:0]                    e_f;
    logic [OB-1:0]                    e_l;
    logic [OB:0]                      e_len;
    logic                             e_hit;
    logic                             e_touch;
    logic                             e_head_all;
    logic                             rd_go;
    logic [AW-1:0]                    rd_addr;
    logic                             e_below;
    logic                             tch;
    logic                             n1_v;
    logic [EW-1:0]                    n1;
    logic                             n2_v;
    logic [EW-1:0]                    n2;
    logic                             wen;
    logic [EW-1:0]                    wdata;
    logic [OB-1:0]                    wr_f;
    logic [OB-1:0]                    wr_l;
    logic [OB:0]                      wr_len;
    logic                             wr_head_all;
    logic                             carry_v_next;
    logic [EW-1:0]                    carry_next;
    logic                             emitted_next;
    logic [OB-1:0]                    mlo_next;
    logic [OB-1:0]                    mhi_next;
    logic                             room;
    logic [CW+srst_pkg::COUNT_OUT_W-1:0] cnt_ext;

    assign csize      = (chunk_reg == '0) ? srst_pkg::CHUNK_W'(DEFAULT_CHUNK_SIZE) : chunk_reg;
    assign prod_c     = {{(PW-srst_pkg::SEG_W){1'b0}}, seg_reg}
                        * {{(PW-srst_pkg::CHUNK_W){1'b0}}, csize};
    assign hi64       = prod_reg + {{(PW-srst_pkg::CHUNK_W){1'b0}}, csize} - PW'(1);
    assign total64    = {{(PW-OB){1'b0}}, total_reg};
    assign tm1        = total_reg - OB'(1);
    assign size_known = (total_reg != '0);
    assign cfg_ext    = {{(64-srst_pkg::CFG_DATA_W){1'b0}}, cfg_data};
    assign room       = (count_reg != CW'(MAX_RANGES));

    assign e_f        = rdata_reg[OB-1:0];
    assign e_l        = rdata_reg[EW-1:OB];
    assign e_len      = {1'b0, e_l} - {1'b0, e_f} + (OB+1)'(1);
    assign e_hit      = (e_f <= key_lo_reg) && (e_l >= key_hi_reg);
    assign e_touch    = (({1'b0, e_l} + (OB+1)'(1)) >= {1'b0, key_lo_reg})
                        && ({1'b0, e_f} <= ({1'b0, key_hi_reg} + (OB+1)'(1)));
    assign e_head_all = size_known && (e_f == '0) && (e_l >= tm1);

    assign rd_go   = (cmd.scan_step || cmd.rw_step) && (rd_idx_reg != count_reg);
    assign rd_addr = rd_idx_reg[AW-1:0];

    assign stat.pass_done    = (rd_idx_reg == count_reg) && !pv_reg;
    assign stat.need_rewrite = ((op_reg == srst_pkg::OP_MARK) && !reversed_reg && !past_reg
                                && !cov_reg && (touch_reg || room))
                               || ((op_reg == srst_pkg::OP_CLIP) && size_known);

    // Rewrite walk: entries stream through in order, at most one write per cycle.
    always_comb
    begin
        e_below      = ({1'b0, e_l} + (OB+1)'(1)) < {1'b0, key_lo_reg};
        tch          = !e_below && ({1'b0, e_f} <= ({1'b0, key_hi_reg} + (OB+1)'(1)));
        n1_v         = 1'b0;
        n1           = rdata_reg;
        n2_v         = 1'b0;
        n2           = rdata_reg;
        emitted_next = emitted_reg;
        mlo_next     = mlo_reg;
        mhi_next     = mhi_reg;
        wen          = 1'b0;
        wdata        = carry_reg;
        carry_v_next = carry_v_reg;
        carry_next   = carry_reg;

        if (cmd.rw_step && pv_reg)
        begin
            if (op_reg == srst_pkg::OP_MARK)
            begin
                if (e_below)
                begin
                    n1_v = 1'b1;
                end
                else if (tch)
                begin
                    mlo_next = (e_f < mlo_reg) ? e_f : mlo_reg;
                    mhi_next = (e_l > mhi_reg) ? e_l : mhi_reg;
                end
                else if (!emitted_reg)
                begin
                    n1_v         = 1'b1;
                    n1           = {mhi_reg, mlo_reg};
                    n2_v         = 1'b1;
                    emitted_next = 1'b1;
                end
                else
                begin
                    n1_v = 1'b1;
                end
            end
            else if (e_f < total_reg)
            begin
                n1_v = 1'b1;
                n1   = {((e_l > tm1) ? tm1 : e_l), e_f};
            end

            if (carry_v_reg)
            begin
                wen          = 1'b1;
                wdata        = carry_reg;
                carry_v_next = n1_v;
                carry_next   = n1;
            end
            else if (n1_v)
            begin
                wen          = 1'b1;
                wdata        = n1;
                carry_v_next = n2_v;
                carry_next   = n2;
            end
        end
        else if (cmd.flush)
        begin
            if (carry_v_reg)
            begin
                wen   = 1'b1;
                wdata = carry_reg;
            end
            else if ((op_reg == srst_pkg::OP_MARK) && !emitted_reg)
            begin
                wen   = 1'b1;
                wdata = {mhi_reg, mlo_reg};
            end
            carry_v_next = 1'b0;
        end
    end

    assign wr_f        = wdata[OB-1:0];
    assign wr_l        = wdata[EW-1:OB];
    assign wr_len      = {1'b0, wr_l} - {1'b0, wr_f} + (OB+1)'(1);
    assign wr_head_all = size_known && (wr_f == '0) && (wr_l >= tm1);

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[w_reg[AW-1:0]] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            chunk_reg   <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            pv_reg      <= 1'b0;
            w_reg       <= '0;
            carry_v_reg <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == srst_pkg::CFG_TOTAL_SIZE)
                begin
                    total_reg <= cfg_ext[OB-1:0];
                end
                else
                begin
                    chunk_reg <= cfg_data[srst_pkg::CHUNK_W-1:0];
                end
            end
            if (cmd.scan_start || cmd.rw_start)
            begin
                rd_idx_reg  <= '0;
                pv_reg      <= 1'b0;
                w_reg       <= '0;
                carry_v_reg <= 1'b0;
                emitted_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step || cmd.rw_step)
                begin
                    pv_reg <= rd_go;
                    if (rd_go)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                end
                carry_v_reg <= carry_v_next;
                emitted_reg <= emitted_next;
                if (wen)
                begin
                    w_reg <= w_reg + CW'(1);
                end
                if (cmd.flush)
                begin
                    count_reg <= w_reg + (wen ? CW'(1) : CW'(0));
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= srst_pkg::op_t'(in_op);
            first_in_reg <= in_first;
            last_in_reg  <= in_last;
            seg_reg      <= in_seg;
        end
        if (cmd.prep)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.keys)
        begin
            key_lo_reg   <= first_in_reg;
            key_hi_reg   <= last_in_reg;
            reversed_reg <= 1'b0;
            past_reg     <= 1'b0;
            nocov_reg    <= 1'b1;
            case (op_reg)
                srst_pkg::OP_MARK:
                begin
                    if (size_known && (last_in_reg >= total_reg))
                    begin
                        key_hi_reg <= tm1;
                    end
                    reversed_reg <= first_in_reg > last_in_reg;
                    past_reg     <= size_known && (first_in_reg >= total_reg);
                end
                srst_pkg::OP_QUERY:
                begin
                    reversed_reg <= first_in_reg > last_in_reg;
                    nocov_reg    <= first_in_reg > last_in_reg;
                end
                srst_pkg::OP_SEGMENT:
                begin
                    key_lo_reg <= prod_reg[OB-1:0];
                    key_hi_reg <= (hi64 >= total64) ? tm1 : hi64[OB-1:0];
                    nocov_reg  <= !size_known || (prod_reg >= total64);
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan_start || cmd.rw_start)
        begin
            head_reg <= 1'b1;
            sum_reg  <= '0;
            all_reg  <= 1'b0;
        end
        if (cmd.scan_start)
        begin
            cov_reg   <= 1'b0;
            touch_reg <= 1'b0;
        end
        if (cmd.rw_start)
        begin
            mlo_reg <= key_lo_reg;
            mhi_reg <= key_hi_reg;
        end
        else
        begin
            mlo_reg <= mlo_next;
            mhi_reg <= mhi_next;
        end
        if (cmd.scan_step && pv_reg)
        begin
            head_reg  <= 1'b0;
            cov_reg   <= cov_reg || e_hit;
            touch_reg <= touch_reg || e_touch;
            sum_reg   <= sum_reg + e_len;
            if (head_reg)
            begin
                all_reg <= e_head_all;
            end
        end
        if (wen)
        begin
            sum_reg <= sum_reg + wr_len;
            if (w_reg == '0)
            begin
                all_reg <= wr_head_all;
            end
        end
        carry_reg <= carry_next;
        if (cmd.decide)
        begin
            if (reversed_reg)
            begin
                status_reg <= srst_pkg::ST_REVERSED;
            end
            else if ((op_reg == srst_pkg::OP_MARK) && !past_reg && !cov_reg
                     && !touch_reg && !room)
            begin
                status_reg <= srst_pkg::ST_FULL;
            end
            else
            begin
                status_reg <= srst_pkg::ST_OK;
            end
            cov_out_reg <= ((op_reg == srst_pkg::OP_QUERY) || (op_reg == srst_pkg::OP_SEGMENT))
                           && !nocov_reg && cov_reg;
        end
        if (cmd.commit)
        begin
            res_status  <= status_reg;
            res_covered <= cov_out_reg;
            res_bytes   <= sum_reg;
            res_all     <= all_reg;
            res_count   <= cnt_ext[srst_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign cnt_ext = {{srst_pkg::COUNT_OUT_W{1'b0}}, count_reg};

endmodule

@@ hw/rtl/sorted_range_set_tracker.sv @@
// Top level of the sorted range set tracker.
//
// Channel  Direction  Handshake                  Content
// s_*      in         s_tvalid / s_tready        one item: op, range, segment index
// m_*      out        m_tvalid / m_tready        one result per item
// cfg_*    in         cfg_valid / cfg_ready      register write, index and data
//
// Each item is handled in passes over the table memory, walked one entry per cycle
// through its single registered read port, first to scan and then, when the table
// must change, to merge, insert or trim in place.
// Reset clears the entry count and both registers; table entries need no clearing.
// A result waits in the output register while the next item is taken; an item whose
// result finds the register still full stalls until it is taken. cfg_ready stays high.
module sorted_range_set_tracker
#(
    parameter int MAX_RANGES                  = 64,
    parameter int OFFSET_BITS                 = 48,
    parameter int unsigned DEFAULT_CHUNK_SIZE = 1048576,
    localparam int IN_W  = ((2 * OFFSET_BITS + srst_pkg::SEG_W + 7) / 8) * 8,
    localparam int OUT_W = ((OFFSET_BITS + 12 + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // range_first, range_last, segment number, zero fill
    input  logic [IN_W-1:0]                 s_tdata,
    // op
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, covered, bytes_done, all_done, range_count, zero fill
    output logic [OUT_W-1:0]                m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [srst_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int OB = OFFSET_BITS;

    srst_pkg::cmd_t  cmd;
    srst_pkg::stat_t stat;

    logic [1:0]                          res_status;
    logic                                res_covered;
    logic [OB:0]                         res_bytes;
    logic                                res_all;
    logic [srst_pkg::COUNT_OUT_W-1:0]    res_count;

    assign cfg_ready = 1'b1;

    srst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srst_datapath
    #(
        .MAX_RANGES         (MAX_RANGES),
        .OFFSET_BITS        (OFFSET_BITS),
        .DEFAULT_CHUNK_SIZE (DEFAULT_CHUNK_SIZE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_tuser),
        .in_first    (s_tdata[OB-1:0]),
        .in_last     (s_tdata[2*OB-1:OB]),
        .in_seg      (s_tdata[2*OB+srst_pkg::SEG_W-1:2*OB]),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_status  (res_status),
        .res_covered (res_covered),
        .res_bytes   (res_bytes),
        .res_all     (res_all),
        .res_count   (res_count)
    );

    assign m_tdata = {{(OUT_W-OB-12){1'b0}}, res_count, res_all, res_bytes,
                      res_covered, res_status};

endmodule

@@ hw/rtl/srst_checker.sv @@
// Port-level assertions for the sorted range set tracker and their bind.
module srst_checker
#(
    parameter int OFFSET_BITS = 48,
    parameter int OUT_W       = 64
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int OB = OFFSET_BITS;

    logic [1:0]  res_status;
    logic        res_covered;
    logic [OB:0] res_bytes;
    logic        res_all;

    assign res_status  = m_tdata[1:0];
    assign res_covered = m_tdata[2];
    assign res_bytes   = m_tdata[OB+3:3];
    assign res_all     = m_tdata[OB+4];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res_status <= srst_pkg::ST_FULL)
        else $error("undefined status code");

    a_reversed_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_status == srst_pkg::ST_REVERSED) |-> !res_covered)
        else $error("reversed range reported as covered");

    a_all_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_all |-> res_bytes != '0)
        else $error("whole file reported done with no bytes covered");

endmodule

bind sorted_range_set_tracker srst_checker
#(
    .OFFSET_BITS (OFFSET_BITS),
    .OUT_W       (OUT_W)
)
u_srst_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/srst_checker.sv @@
// Checker for the sorted range set tracker: tracks the table, predicts and compares results.
`timescale 1ns / 100ps

module srst_scoreboard
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data,
    output int           fail_count,
    output int           results_owed
);

    localparam int TABLE_DEPTH = 64;
    localparam longint unsigned DEF_CHUNK = 64'd1048576;

    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [6:0]  range_count;
        logic        all_done;
        logic [48:0] bytes_done;
        logic        covered;
        logic [1:0]  status;
    } tracker_result_t;

    longint unsigned tbl_first [TABLE_DEPTH];
    longint unsigned tbl_last  [TABLE_DEPTH];
    int              tbl_count;
    longint unsigned file_size;
    longint unsigned seg_size;
    tracker_result_t owed_results[$];
    int              mismatches;

    function automatic bit span_covered(longint unsigned lo, longint unsigned hi);
        if (lo > hi)
            return 1'b0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_first[i] <= lo && tbl_last[i] >= hi)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic longint unsigned bytes_covered();
        longint unsigned s;
        s = 0;
        for (int i = 0; i < tbl_count; i++)
            s += tbl_last[i] - tbl_first[i] + 1;
        return s;
    endfunction

    function automatic srst_pkg::status_t mark_done(longint unsigned lo, longint unsigned hi);
        int a, b, gone;
        longint unsigned mlo, mhi;
        if (lo > hi)
            return srst_pkg::ST_REVERSED;
        if (file_size != 0) begin
            if (lo >= file_size)
                return srst_pkg::ST_OK;
            if (hi >= file_size)
                hi = file_size - 1;
        end
        if (span_covered(lo, hi))
            return srst_pkg::ST_OK;
        a = 0;
        while (a < tbl_count && tbl_last[a] + 1 < lo)
            a++;
        mlo = lo;
        mhi = hi;
        b = a;
        while (b < tbl_count && tbl_first[b] <= mhi + 1) begin
            if (tbl_first[b] < mlo)
                mlo = tbl_first[b];
            if (tbl_last[b] > mhi)
                mhi = tbl_last[b];
            b++;
        end
        if (b > a) begin
            tbl_first[a] = mlo;
            tbl_last[a]  = mhi;
            gone = b - a - 1;
            for (int i = b; i < tbl_count; i++) begin
                tbl_first[i - gone] = tbl_first[i];
                tbl_last[i - gone]  = tbl_last[i];
            end
            tbl_count -= gone;
            return srst_pkg::ST_OK;
        end
        if (tbl_count >= TABLE_DEPTH)
            return srst_pkg::ST_FULL;
        for (int i = tbl_count; i > a; i--) begin
            tbl_first[i] = tbl_first[i - 1];
            tbl_last[i]  = tbl_last[i - 1];
        end
        tbl_first[a] = mlo;
        tbl_last[a]  = mhi;
        tbl_count++;
        return srst_pkg::ST_OK;
    endfunction

    function automatic void trim_to_size();
        int w;
        w = 0;
        if (file_size == 0)
            return;
        for (int r = 0; r < tbl_count; r++) begin
            if (tbl_first[r] < file_size) begin
                tbl_first[w] = tbl_first[r];
                tbl_last[w]  = (tbl_last[r] > file_size - 1) ? file_size - 1 : tbl_last[r];
                w++;
            end
        end
        tbl_count = w;
    endfunction

    function automatic bit segment_covered(longint unsigned idx);
        longint unsigned c, lo, hi;
        if (file_size == 0)
            return 1'b0;
        c  = (seg_size != 0) ? seg_size : DEF_CHUNK;
        lo = idx * c;
        hi = lo + c - 1;
        if (hi >= file_size)
            hi = file_size - 1;
        return span_covered(lo, hi);
    endfunction

    function automatic tracker_result_t apply_item(srst_pkg::op_t op, longint unsigned lo,
                                                   longint unsigned hi, longint unsigned seg);
        tracker_result_t r;
        r = '0;
        r.status = srst_pkg::ST_OK;
        case (op)
            srst_pkg::OP_MARK:    r.status = mark_done(lo, hi);
            srst_pkg::OP_QUERY:
                if (lo > hi)
                    r.status = srst_pkg::ST_REVERSED;
                else
                    r.covered = span_covered(lo, hi);
            srst_pkg::OP_SEGMENT: r.covered = segment_covered(seg);
            default:              trim_to_size();
        endcase
        r.bytes_done  = bytes_covered();
        r.all_done    = (file_size != 0) && span_covered(0, file_size - 1);
        r.range_count = tbl_count[6:0];
        return r;
    endfunction

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                         want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        tracker_result_t want, got;
        if (!rst_n) begin
            tbl_count  = 0;
            file_size  = 0;
            seg_size   = 0;
            mismatches = 0;
            owed_results.delete();
            fail_count   <= 0;
            results_owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == srst_pkg::CFG_TOTAL_SIZE)
                    file_size = 64'(cfg_data);
                else
                    seg_size = 64'(cfg_data[31:0]);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[59:0];
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0h with no transaction pending", $realtime,
                                 m_tdata);
                end else begin
                    want = owed_results.pop_front();
                    report_field("status", 64'(want.status), 64'(got.status));
                    report_field("covered", 64'(want.covered), 64'(got.covered));
                    report_field("bytes_done", 64'(want.bytes_done), 64'(got.bytes_done));
                    report_field("all_done", 64'(want.all_done), 64'(got.all_done));
                    report_field("range_count", 64'(want.range_count),
                                 64'(got.range_count));
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_item(srst_pkg::op_t'(s_tuser),
                                                  64'(s_tdata[47:0]), 64'(s_tdata[95:48]),
                                                  64'(s_tdata[127:96])));
            fail_count   <= mismatches;
            results_owed <= owed_results.size();
        end
    end

endmodule

@@ verif/tb_sorted_range_set_tracker.sv @@
// Testbench top for the sorted range set tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_range_set_tracker;

    localparam longint unsigned OFS_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int IDLE_LIMIT = 5000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = srst_pkg::OP_MARK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = srst_pkg::CFG_TOTAL_SIZE;
    logic [47:0]  cfg_data = '0;

    int  fail_count;
    int  results_owed;
    bit  calm = 1'b0;
    bit  hold_wanted = 1'b0;
    int  stuck_cycles = 0;
    longint unsigned cur_size;
    longint unsigned span;

    always #2 clk = ~clk;

    sorted_range_set_tracker u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    srst_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .results_owed(results_owed)
    );

    task automatic send_item(srst_pkg::op_t op, longint unsigned lo, longint unsigned hi,
                             longint unsigned seg);
        s_tuser  <= op;
        s_tdata  <= {seg[31:0], hi[47:0], lo[47:0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic write_reg(srst_pkg::cfg_idx_t idx, longint unsigned value);
        cfg_index <= idx;
        cfg_data  <= value[47:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The block is idle once every result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic longint unsigned wide_rand();
        return {$urandom, $urandom} & OFS_MAX;
    endfunction

    task automatic random_item();
        longint unsigned lo, hi;
        int pick;
        pick = $urandom_range(0, 99);
        if (span == 0)
            lo = wide_rand();
        else
            lo = $urandom_range(0, 32'(span - 1));
        hi = lo + $urandom_range(0, 40);
        if (pick < 5)
            send_item(srst_pkg::op_t'($urandom_range(0, 3)), wide_rand(), wide_rand(),
                      $urandom);
        else if (pick < 55)
            send_item(srst_pkg::OP_MARK, lo, hi & OFS_MAX, $urandom);
        else if (pick < 60)
            send_item(srst_pkg::OP_MARK, hi & OFS_MAX, lo, $urandom);
        else if (pick < 78)
            send_item(srst_pkg::OP_QUERY, lo, (hi + $urandom_range(0, 200)) & OFS_MAX,
                      $urandom);
        else if (pick < 82)
            send_item(srst_pkg::OP_QUERY, hi + 1, lo, $urandom);
        else if (pick < 96)
            send_item(srst_pkg::OP_SEGMENT, lo, hi, $urandom_range(0, 40));
        else
            send_item(srst_pkg::OP_CLIP, lo, hi, $urandom);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from unknown size and default chunk.
        send_item(srst_pkg::OP_MARK, 0, 0, 0);
        send_item(srst_pkg::OP_MARK, OFS_MAX, OFS_MAX, 32'hFFFF_FFFF);
        send_item(srst_pkg::OP_QUERY, 0, 0, 0);
        send_item(srst_pkg::OP_QUERY, OFS_MAX, OFS_MAX, 0);
        send_item(srst_pkg::OP_MARK, 10, 5, 0);
        send_item(srst_pkg::OP_QUERY, 10, 5, 0);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 0);
        send_item(srst_pkg::OP_CLIP, 0, 0, 0);
        send_item(srst_pkg::OP_MARK, 0, OFS_MAX, 0);
        send_item(srst_pkg::OP_QUERY, 0, OFS_MAX, 0);
        drain();
        write_reg(srst_pkg::CFG_TOTAL_SIZE, 1000);
        write_reg(srst_pkg::CFG_CHUNK_SIZE, 100);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 3);
        send_item(srst_pkg::OP_CLIP, 0, 0, 0);
        send_item(srst_pkg::OP_MARK, 1500, 1600, 0);
        send_item(srst_pkg::OP_MARK, 900, 5000, 0);
        send_item(srst_pkg::OP_MARK, 950, 960, 0);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 9);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 20);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 32'hFFFF_FFFF);
        send_item(srst_pkg::OP_MARK, 100, 200, 0);
        send_item(srst_pkg::OP_MARK, 201, 300, 0);
        drain();
        write_reg(srst_pkg::CFG_CHUNK_SIZE, 0);
        send_item(srst_pkg::OP_SEGMENT, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: cur_size = $urandom_range(200, 3000);
                1: cur_size = 0;
                2: cur_size = OFS_MAX;
                3: cur_size = 1;
                default: cur_size = wide_rand();
            endcase
            write_reg(srst_pkg::CFG_TOTAL_SIZE, cur_size);
            case (ph % 4)
                0: write_reg(srst_pkg::CFG_CHUNK_SIZE, 0);
                1: write_reg(srst_pkg::CFG_CHUNK_SIZE,
                             64'hFFFF_0000_0000 | $urandom_range(1, 64));
                2: write_reg(srst_pkg::CFG_CHUNK_SIZE, 32'hFFFF_FFFF);
                default: write_reg(srst_pkg::CFG_CHUNK_SIZE, 1);
            endcase
            span = (ph == 4 || ph == 9) ? 0 : $urandom_range(300, 4000);
            if (ph == 9)
                calm = 1'b1;
            for (int n = 0; n < 165; n++) begin
                if (ph == 1 && n == 60)
                    hold_wanted = 1'b1;
                random_item();
            end
            drain();
            // A tiny size followed by a clip empties most of the table.
            if (ph % 3 == 2) begin
                write_reg(srst_pkg::CFG_TOTAL_SIZE, 1);
                send_item(srst_pkg::OP_CLIP, 0, 0, 0);
                drain();
            end
        end

        drain();
        if (fail_count == 0 && results_owed == 0)
            $display("[sorted_range_set_tracker] OK");
        else
            $display("[sorted_range_set_tracker] ERROR");
        $finish;
    end

    initial begin
        @(posedge rst_n);
        forever begin
            if (hold_wanted) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_wanted = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("[sorted_range_set_tracker] ERROR");
            $finish;
        end
    end

endmodule
